// ----- design/window_median_filter_top_assert.svh -----
// Assertion macros shared by the median filter modules.
`ifndef WINDOW_MEDIAN_FILTER_TOP_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_TOP_ASSERT_SVH
`ifndef SYNTH
`define WMF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define WMF_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");
`else
`define WMF_ASSERT(lbl, prop)
`define WMF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- design/wmf_pkg.sv -----
// Types and constants of the window median filter.
package wmf_pkg;
   localparam int WINDOW   = 3;
   localparam int HALF     = WINDOW / 2;
   localparam int SIDE     = 2 * HALF + 1;
   localparam int NTAP     = SIDE * SIDE;
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int PIX_W    = 8;
   localparam int DIM_W    = 11;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int WARM_W   = $clog2(MAX_COLS * HALF + HALF + 1);
   localparam int LINE_W   = (SIDE - 1) * PIX_W;
   localparam int CNT_W    = $clog2(NTAP + 1);
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);
   localparam int ADDR_W   = 3;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [NTAP-1:0][PIX_W-1:0] win_type;
   typedef logic [NTAP-1:0] mask_type;

   typedef struct packed {
      win_type  win;
      mask_type mask;
      logic     last;
   } item_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic             restart;
   } cfg_type;
endpackage

// ----- design/wmf_if.sv -----
// Handshake interfaces of the pixel and result channels.
interface wmf_req_if;
   import wmf_pkg::*;
   logic    valid;
   logic    ready;
   pix_type pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface wmf_rsp_if;
   import wmf_pkg::*;
   logic    valid;
   logic    ready;
   pix_type pixel_out;
   logic    frame_last;
   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- design/wmf_front.sv -----
// Front end: position tracking, line memory, window assembly and border masks.
module wmf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  wmf_pkg::cfg_type       cfg,
   wmf_req_if.sink                req_if,
   input  logic [wmf_pkg::QCNT_W-1:0] q_count,
   output logic                   push_valid,
   output wmf_pkg::item_type      push_item
);
   import wmf_pkg::*;
   `include "window_median_filter_top_assert.svh"

   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [WARM_W-1:0] warm_ff, warm_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic              s1_valid_ff;
   pix_type           s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_emit_ff;
   mask_type          s1_mask_ff;
   logic              s1_last_ff;
   logic [LINE_W-1:0] line_mem [MAX_COLS];
   logic [LINE_W-1:0] rd_ff;
   logic [LINE_W-1:0] wr_data;
   win_type           win_ff, win_in;
   pix_type           colv [SIDE];
   logic              accept;
   logic              emit;
   logic              last;
   logic [WARM_W-1:0] delay;
   mask_type          mask;
   logic [SIDE-1:0]   row_ok;
   logic [SIDE-1:0]   col_ok;

   assign req_if.ready = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid_ff)) <
                         (QCNT_W + 1)'(QDEPTH);
   assign accept = req_if.valid && req_if.ready;
   assign delay  = WARM_W'(cfg.cols) * WARM_W'(HALF) + WARM_W'(HALF);
   assign emit   = (warm_ff == delay);
   assign last   = emit && ((DIM_W'(out_row_ff) + 1'b1) == cfg.rows) &&
                   ((DIM_W'(out_col_ff) + 1'b1) == cfg.cols);

   always_comb begin
      int rr;
      int cc;
      for (int d = 0; d < SIDE; d++) begin
         rr = int'(out_row_ff) + d - HALF;
         cc = int'(out_col_ff) + d - HALF;
         row_ok[d] = (rr >= 0) && (rr < int'(cfg.rows));
         col_ok[d] = (cc >= 0) && (cc < int'(cfg.cols));
      end
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            mask[r * SIDE + c] = row_ok[r] && col_ok[c];
         end
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      warm_in    = warm_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (cfg.restart || (accept && last)) begin
         in_col_in  = '0;
         warm_in    = '0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (accept) begin
         if ((DIM_W'(in_col_ff) + 1'b1) == cfg.cols) begin
            in_col_in = '0;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (emit) begin
            if ((DIM_W'(out_col_ff) + 1'b1) == cfg.cols) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end else begin
            warm_in = warm_ff + 1'b1;
         end
      end
   end

   always_comb begin
      wr_data[PIX_W-1:0] = s1_pix_ff;
      for (int j = 1; j < SIDE - 1; j++) begin
         wr_data[j*PIX_W +: PIX_W] = rd_ff[(j-1)*PIX_W +: PIX_W];
      end
      colv[SIDE-1] = s1_pix_ff;
      for (int j = 0; j < SIDE - 1; j++) begin
         colv[SIDE-2-j] = rd_ff[j*PIX_W +: PIX_W];
      end
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE - 1; c++) begin
            win_in[r * SIDE + c] = win_ff[r * SIDE + c + 1];
         end
         win_in[r * SIDE + SIDE - 1] = colv[r];
      end
   end

   assign push_valid     = s1_valid_ff && s1_emit_ff;
   assign push_item.win  = win_in;
   assign push_item.mask = s1_mask_ff;
   assign push_item.last = s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         warm_ff     <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         warm_ff     <= warm_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_pix_ff  <= req_if.pixel_in;
         s1_col_ff  <= in_col_ff;
         s1_emit_ff <= emit;
         s1_mask_ff <= mask;
         s1_last_ff <= last;
         if (s1_valid_ff && (s1_col_ff == in_col_ff)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= line_mem[in_col_ff];
         end
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
         win_ff              <= win_in;
      end
   end

   `WMF_ASSERT(a_accept_staged, accept |=> s1_valid_ff)
   `WMF_ASSERT(a_centre_in_frame, push_valid |-> push_item.mask[NTAP / 2])
endmodule

// ----- design/wmf_queue.sv -----
// Short queue of assembled windows between the front and back ends.
module wmf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  wmf_pkg::item_type          push_item,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output wmf_pkg::item_type          pop_item,
   output logic [wmf_pkg::QCNT_W-1:0] count
);
   import wmf_pkg::*;
   `include "window_median_filter_top_assert.svh"

   item_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
      end
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `WMF_ASSERT(a_no_overflow, push_valid |-> (count_ff != QCNT_W'(QDEPTH)))
   `WMF_ASSERT(a_idle_holds, (!push_valid && !pop) |=> $stable(count_ff))
endmodule

// ----- design/wmf_back.sv -----
// Back end: rank network that picks the lower median and the result register.
module wmf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  wmf_pkg::item_type pop_item,
   wmf_rsp_if.source         rsp_if
);
   import wmf_pkg::*;
   `include "window_median_filter_top_assert.svh"

   logic             a_valid_ff;
   win_type          a_win_ff;
   mask_type         a_sel_ff;
   logic             a_last_ff;
   logic             rsp_valid_ff;
   pix_type          rsp_pix_ff;
   logic             rsp_last_ff;
   mask_type         sel_in;
   logic [CNT_W-1:0] cnt;
   logic [CNT_W-1:0] mid;
   pix_type          pick;
   logic             b_load;
   logic             a_load;

   assign b_load    = a_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign pop_ready = !a_valid_ff || b_load;
   assign a_load    = pop_valid && pop_ready;
   assign cnt       = CNT_W'($countones(pop_item.mask));
   assign mid       = (cnt - 1'b1) >> 1;

   always_comb begin
      logic [CNT_W-1:0] rank;
      for (int i = 0; i < NTAP; i++) begin
         rank = '0;
         for (int j = 0; j < NTAP; j++) begin
            if (j != i && pop_item.mask[j] &&
                ((pop_item.win[j] < pop_item.win[i]) ||
                 ((pop_item.win[j] == pop_item.win[i]) && (j < i)))) begin
               rank = rank + 1'b1;
            end
         end
         sel_in[i] = pop_item.mask[i] && (rank == mid);
      end
   end

   always_comb begin
      pick = '0;
      for (int i = 0; i < NTAP; i++) begin
         pick = pick | (a_win_ff[i] & {PIX_W{a_sel_ff[i]}});
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_out  = rsp_pix_ff;
   assign rsp_if.frame_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_ready) begin
            a_valid_ff <= pop_valid;
         end
         if (b_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (a_load) begin
         a_win_ff  <= pop_item.win;
         a_sel_ff  <= sel_in;
         a_last_ff <= pop_item.last;
      end
      if (b_load) begin
         rsp_pix_ff  <= pick;
         rsp_last_ff <= a_last_ff;
      end
   end

   `WMF_ASSERT(a_one_median, a_valid_ff |-> $onehot(a_sel_ff))
   `WMF_ASSERT(a_result_loaded, b_load |=> rsp_valid_ff)
endmodule

// ----- design/window_median_filter_top.sv -----
// Top level of the streaming window median filter with its register port.
// The filter takes one 8-bit pixel per clock in raster order and returns the lower median of
// the in-frame 3x3 neighbourhood of each pixel; a result appears once the pixel a row and a
// column further on has arrived, and after each frame the source sends image_cols+1 filler
// transactions to flush the last results. Without output stalls the sustained rate
// is one transaction per cycle in both directions, set by the simple dual-port line memory
// (one read and one write per pixel) and the rank network. A result passes the input stage,
// queue, rank stage and result register; a four-entry queue between the window assembly
// and the median stage absorbs output stalls. Writing either register restarts the frame.
module window_median_filter_top (
   input  logic                       clock,
   input  logic                       reset,
   wmf_req_if.sink                    req_if,
   wmf_rsp_if.source                  rsp_if,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [wmf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import wmf_pkg::*;

   logic [DIM_W-1:0]  rows_ff, rows_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;
   logic              wr;
   cfg_type           cfg;
   logic              push_valid;
   item_type          push_item;
   logic              pop_valid;
   logic              pop_ready;
   item_type          pop_item;
   logic [QCNT_W-1:0] q_count;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > maxv) begin
         r = DIM_W'(maxv);
      end
      return r;
   endfunction

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_COLS) ? 32'(cols_ff) : 32'(rows_ff);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr) begin
         if (csr_paddr[2] == REG_ROWS) begin
            rows_in = clamp_dim(csr_pwdata[DIM_W-1:0], MAX_ROWS);
         end else begin
            cols_in = clamp_dim(csr_pwdata[DIM_W-1:0], MAX_COLS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(MAX_ROWS);
         cols_ff <= DIM_W'(MAX_COLS);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign cfg.rows    = rows_ff;
   assign cfg.cols    = cols_ff;
   assign cfg.restart = wr;

   wmf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_if     (req_if),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   wmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .count      (q_count)
   );

   wmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_if    (rsp_if)
   );
endmodule

// ----- verif/wmf_tb.sv -----
// Testbench of the window median filter: random frames checked against a frame-buffer predictor.
`timescale 1ns / 1ps
module tb;
   import wmf_pkg::*;

   typedef struct {
      pix_type pixel;
      logic    last;
   } median_result_type;

   localparam logic [ADDR_W-1:0] ROWS_ADDR = {REG_ROWS, 2'b00};
   localparam logic [ADDR_W-1:0] COLS_ADDR = {REG_COLS, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   wmf_req_if req_if ();
   wmf_rsp_if rsp_if ();

   window_median_filter_top uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   pix_type pending_pixels[$];
   median_result_type expected_medians[$];
   pix_type frame_buf [0:MAX_ROWS*MAX_COLS-1];
   int frame_rows = MAX_ROWS;
   int frame_cols = MAX_COLS;
   int frame_pos = 0;
   int accepted_items = 0;
   int loaded_items = 0;
   int failures = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_left = 0;
   int stall_mode = 0;
   int sent_total = 0;

   function automatic int clamp_dim(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void predict_median(pix_type pixel);
      int delay;
      int q;
      int r;
      int c;
      int n;
      int key;
      int j;
      int vals[9];
      median_result_type res;
      delay = frame_cols * HALF + HALF;
      if (frame_pos < frame_rows * frame_cols) frame_buf[frame_pos] = pixel;
      if (frame_pos >= delay) begin
         q = frame_pos - delay;
         r = q / frame_cols;
         c = q % frame_cols;
         n = 0;
         for (int rr = r - HALF; rr <= r + HALF; rr++) begin
            for (int cc = c - HALF; cc <= c + HALF; cc++) begin
               if (rr >= 0 && rr < frame_rows && cc >= 0 && cc < frame_cols) begin
                  vals[n] = int'(frame_buf[rr * frame_cols + cc]);
                  n++;
               end
            end
         end
         for (int i = 1; i < n; i++) begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > key) begin
               vals[j + 1] = vals[j];
               j--;
            end
            vals[j + 1] = key;
         end
         res.pixel = pix_type'(vals[(n - 1) / 2]);
         res.last = (q == frame_rows * frame_cols - 1);
         expected_medians.push_back(res);
      end
      frame_pos++;
      if (frame_pos >= frame_rows * frame_cols + delay) frame_pos = 0;
   endfunction

   // Driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.pixel_in <= '0;
      end else if (accepted_items == loaded_items) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            req_if.pixel_in <= pending_pixels.pop_front();
            req_if.valid <= 1'b1;
            loaded_items++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 60);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern changes from segment to segment.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(1, 80);
         stall_mode = $urandom_range(0, 3);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         2: rsp_if.ready <= ($urandom_range(0, 9) == 0);
         default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      median_result_type exp_res;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            accepted_items++;
            predict_median(req_if.pixel_in);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected result pixel_out=%0d frame_last=%0d", $time,
                        rsp_if.pixel_out, rsp_if.frame_last);
               failures++;
            end else begin
               exp_res = expected_medians.pop_front();
               if (rsp_if.pixel_out !== exp_res.pixel) begin
                  $display("%0t: pixel_out expected %0d actual %0d", $time, exp_res.pixel,
                           rsp_if.pixel_out);
                  failures++;
               end
               if (rsp_if.frame_last !== exp_res.last) begin
                  $display("%0t: frame_last expected %0d actual %0d", $time, exp_res.last,
                           rsp_if.frame_last);
                  failures++;
               end
            end
         end
      end
   end

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_pixels.size() > 0 || accepted_items != loaded_items
             || expected_medians.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_frame(int rows, int cols);
      wait_drained();
      csr_write(ROWS_ADDR, rows);
      csr_write(COLS_ADDR, cols);
      frame_rows = clamp_dim(rows & 32'h7FF, MAX_ROWS);
      frame_cols = clamp_dim(cols & 32'h7FF, MAX_COLS);
      frame_pos = 0;
   endtask

   task automatic queue_frame(int style);
      int n;
      n = frame_rows * frame_cols;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: pending_pixels.push_back(8'h00);
            1: pending_pixels.push_back(8'hFF);
            2: pending_pixels.push_back((i % 2) ? 8'hFF : 8'h00);
            3: pending_pixels.push_back(pix_type'($urandom_range(0, 3) * 8'h55));
            default: pending_pixels.push_back(pix_type'($urandom_range(0, 255)));
         endcase
      end
      for (int i = 0; i < frame_cols * HALF + HALF; i++)
         pending_pixels.push_back(pix_type'($urandom_range(0, 255)));
      sent_total += n + frame_cols * HALF + HALF;
   endtask

   initial begin
      int rows;
      int cols;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_frame(0, 0);
      queue_frame(4);
      set_frame(1, 2);
      queue_frame(2);
      set_frame(2, 1);
      queue_frame(1);
      set_frame(3, 3);
      queue_frame(2);
      queue_frame(4);
      sent_total = 0;
      while (sent_total < 560) begin
         rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
         cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
         set_frame(rows, cols);
         repeat ($urandom_range(1, 3)) queue_frame($urandom_range(0, 12));
      end
      set_frame(2047, 1);
      queue_frame(4);
      set_frame(4, 32'h805);
      queue_frame(3);
      set_frame(4, 5);
      queue_frame(4);
      wait_drained();
      if (failures == 0 && expected_medians.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule

// ----- window_median_filter_top.f -----
+incdir+design
design/wmf_pkg.sv
design/wmf_if.sv
design/wmf_front.sv
design/wmf_queue.sv
design/wmf_back.sv
design/window_median_filter_top.sv
verif/wmf_tb.sv
